### hdl/ise_pkg.sv
// Package for the integer set engine: command codes, FSM states and
// the controller/datapath command and status structs. No dependencies.
package ise_pkg;

  typedef enum logic [3:0] {
    KIND_ADD       = 4'd0,
    KIND_REMOVE    = 4'd1,
    KIND_CONTAINS  = 4'd2,
    KIND_CLEAR     = 4'd3,
    KIND_UNION     = 4'd4,
    KIND_INTERSECT = 4'd5,
    KIND_SUBTRACT  = 4'd6,
    KIND_SUBSET    = 4'd7,
    KIND_EQUAL     = 4'd8
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_OUTER,
    ST_INNER,
    ST_EMIT,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch input item
    logic scan_clr;   // restart per-set scan
    logic scan_step;  // compare one entry of target set
    logic do_add;     // append value to target set
    logic do_clear;   // zero target count
    logic shift_step; // move one entry down in target set
    logic rm_done;    // decrement target count
    logic outer_clr;  // restart outer index
    logic outer_step; // next outer element
    logic inner_clr;  // restart inner scan
    logic inner_step; // compare one inner entry
    logic cnt_common; // count one common element
    logic pass_b;     // second union pass (B over A)
    logic res_load;   // capture result item
    logic res_elem;   // result carries the pending element
    logic res_last;
    logic pend_load;  // hold current outer element as pending
    logic res_final;  // per-set / compare result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind_perset;
    logic kind_setop;
    logic kind_cmp;
    logic scan_end;   // scan index reached count
    logic found;      // scan hit (sticky)
    logic shift_end;
    logic outer_end;
    logic inner_end;
    logic inner_hit;  // sticky
    logic out_busy;   // result register still full
    logic any_out;    // an element is pending
  } dp_sts_t;

endpackage

### hdl/ise_datapath.sv
// Datapath of the integer set engine: two set memories, counts, scan
// indexes and the output register. Depends on ise_pkg.
module ise_datapath #(
  parameter int Capacity = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ise_pkg::dp_cmd_t cmd_i,
  output ise_pkg::dp_sts_t sts_o,
  input  logic [3:0]      kind_i,
  input  logic            which_set_i,
  input  logic [31:0]     value_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [47:0]     res_data_o,
  output logic            res_user_o,
  output logic            res_last_o
);
  import ise_pkg::*;

  localparam int IW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CW = $clog2(Capacity + 1);

  logic [31:0] mem_a [Capacity];
  logic [31:0] mem_b [Capacity];

  logic [CW-1:0] cnt_a_q, cnt_b_q;
  logic [3:0]    kind_q;
  logic          sel_q;
  logic [31:0]   val_q;
  logic [CW-1:0] idx_q;   // per-set scan / shift index
  logic [CW-1:0] oi_q;    // outer index
  logic [CW-1:0] ii_q;    // inner index
  logic          found_q, hit_q, any_q;
  logic [CW-1:0] common_q;
  logic          pass_b_q;
  logic [31:0]   pend_q;  // element held back until its successor is known

  logic          v_q, last_q, user_q;
  logic [47:0]   data_q;

  logic [CW-1:0] tcnt, ocnt, icnt;
  logic [31:0]   t_rd, t_nx, o_rd, i_rd;
  logic [IW-1:0] idx_w, idx1_w, oi_w, ii_w;
  logic          add_ok;

  assign tcnt   = sel_q ? cnt_b_q : cnt_a_q;
  assign ocnt   = pass_b_q ? cnt_b_q : cnt_a_q;
  assign icnt   = pass_b_q ? cnt_a_q : cnt_b_q;
  assign idx_w  = idx_q[IW-1:0];
  assign idx1_w = IW'(idx_q + CW'(1));
  assign oi_w   = oi_q[IW-1:0];
  assign ii_w   = ii_q[IW-1:0];
  assign t_rd   = sel_q ? mem_b[idx_w] : mem_a[idx_w];
  assign t_nx   = sel_q ? mem_b[idx1_w] : mem_a[idx1_w];
  assign o_rd   = pass_b_q ? mem_b[oi_w] : mem_a[oi_w];
  assign i_rd   = pass_b_q ? mem_a[ii_w] : mem_b[ii_w];
  assign add_ok = cmd_i.do_add && (tcnt < CW'(Capacity));

  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      if (sel_q) mem_b[tcnt[IW-1:0]] <= val_q;
      else mem_a[tcnt[IW-1:0]] <= val_q;
    end else if (cmd_i.shift_step) begin
      if (sel_q) mem_b[idx_w] <= t_nx;
      else mem_a[idx_w] <= t_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      v_q      <= 1'b0;
      last_q   <= 1'b0;
      kind_q   <= '0;
      sel_q    <= 1'b0;
      val_q    <= '0;
      idx_q    <= '0;
      oi_q     <= '0;
      ii_q     <= '0;
      found_q  <= 1'b0;
      hit_q    <= 1'b0;
      any_q    <= 1'b0;
      common_q <= '0;
      pass_b_q <= 1'b0;
      pend_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        kind_q   <= kind_i;
        sel_q    <= which_set_i;
        val_q    <= value_i;
        any_q    <= 1'b0;
        common_q <= '0;
        pass_b_q <= 1'b0;
      end
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (t_rd == val_q) found_q <= 1'b1;
        else idx_q <= idx_q + CW'(1);
      end else if (cmd_i.shift_step) begin
        idx_q <= idx_q + CW'(1);
      end
      if (add_ok || cmd_i.rm_done || cmd_i.do_clear) begin
        if (sel_q) begin
          cnt_b_q <= cmd_i.do_clear ? '0 :
                     add_ok ? cnt_b_q + CW'(1) : cnt_b_q - CW'(1);
        end else begin
          cnt_a_q <= cmd_i.do_clear ? '0 :
                     add_ok ? cnt_a_q + CW'(1) : cnt_a_q - CW'(1);
        end
      end
      if (cmd_i.pass_b) pass_b_q <= 1'b1;
      if (cmd_i.outer_clr) oi_q <= '0;
      else if (cmd_i.outer_step) oi_q <= oi_q + CW'(1);
      if (cmd_i.inner_clr) begin
        ii_q  <= '0;
        hit_q <= 1'b0;
      end else if (cmd_i.inner_step) begin
        if (i_rd == o_rd) hit_q <= 1'b1;
        else ii_q <= ii_q + CW'(1);
      end
      if (cmd_i.cnt_common) common_q <= common_q + CW'(1);
      if (cmd_i.pend_load) begin
        pend_q <= o_rd;
        any_q  <= 1'b1;
      end
      if (cmd_i.res_load) begin
        v_q    <= 1'b1;
        last_q <= cmd_i.res_last;
      end else if (res_ready_i) begin
        v_q <= 1'b0;
      end
    end
  end

  // result payload: answer, refused_full, element, size, empty
  logic          ans, full;
  logic [CW-1:0] rsize, cnt_after;
  logic [5:0]    sz6;

  always_comb begin
    ans       = 1'b0;
    full      = 1'b0;
    cnt_after = tcnt;
    rsize     = cnt_a_q;
    if (cmd_i.res_final) begin
      case (kind_q)
        KIND_ADD: begin
          ans  = !found_q && (tcnt < CW'(Capacity));
          full = !found_q && (tcnt >= CW'(Capacity));
          if (ans) cnt_after = tcnt + CW'(1);
        end
        KIND_REMOVE: begin
          ans = found_q;
          if (found_q) cnt_after = tcnt - CW'(1);
        end
        KIND_CONTAINS: ans = found_q;
        KIND_CLEAR:    cnt_after = '0;
        KIND_SUBSET:   ans = (common_q == cnt_a_q);
        KIND_EQUAL:    ans = (common_q == cnt_a_q) && (cnt_a_q == cnt_b_q);
        default:       ans = 1'b0;
      endcase
      if (kind_q != KIND_SUBSET && kind_q != KIND_EQUAL) rsize = cnt_after;
    end
    sz6 = 6'(rsize);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      data_q <= {7'b0, (rsize == '0), sz6,
                 (cmd_i.res_elem ? pend_q : 32'd0),
                 full, ans};
      user_q <= cmd_i.res_elem;
    end
  end

  assign res_valid_o = v_q;
  assign res_data_o  = data_q;
  assign res_user_o  = user_q;
  assign res_last_o  = last_q;

  always_comb begin
    sts_o.kind_perset = (kind_q <= KIND_CLEAR) || (kind_q > KIND_EQUAL);
    sts_o.kind_setop  = (kind_q == KIND_UNION) || (kind_q == KIND_INTERSECT) ||
                        (kind_q == KIND_SUBTRACT);
    sts_o.kind_cmp    = (kind_q == KIND_SUBSET) || (kind_q == KIND_EQUAL);
    sts_o.scan_end    = (idx_q >= tcnt);
    sts_o.found       = found_q;
    sts_o.shift_end   = (idx_q + CW'(1) >= tcnt);
    sts_o.outer_end   = (oi_q >= ocnt);
    sts_o.inner_end   = (ii_q >= icnt);
    sts_o.inner_hit   = hit_q;
    sts_o.out_busy    = v_q && !res_ready_i;
    sts_o.any_out     = any_q;
  end
endmodule

### hdl/ise_ctrl.sv
// Controller FSM of the integer set engine: sequences scans, shifts and
// result emission. Depends on ise_pkg.
module ise_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [3:0]       kind_i,
  input  ise_pkg::dp_sts_t sts_i,
  output ise_pkg::dp_cmd_t cmd_o
);
  import ise_pkg::*;

  state_e     state_q, state_d;
  logic       pass_b_q, pass_b_d;
  logic [3:0] kind_q;
  logic       emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pass_b_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pass_b_q <= pass_b_d;
    end
  end

  // kind held in datapath is mirrored here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) kind_q <= '0;
    else if (cmd_o.load) kind_q <= kind_i;
  end

  always_comb begin
    if (pass_b_q) begin
      emit = !sts_i.inner_hit;
    end else begin
      case (kind_q)
        KIND_UNION:     emit = 1'b1;
        KIND_INTERSECT: emit = sts_i.inner_hit;
        KIND_SUBTRACT:  emit = !sts_i.inner_hit;
        default:        emit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    pass_b_d   = pass_b_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load      = 1'b1;
          cmd_o.scan_clr  = 1'b1;
          cmd_o.outer_clr = 1'b1;
          cmd_o.inner_clr = 1'b1;
          pass_b_d        = 1'b0;
          state_d = (kind_i >= KIND_UNION && kind_i <= KIND_EQUAL) ? ST_INNER : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.found || sts_i.scan_end) state_d = ST_DONE;
        else cmd_o.scan_step = 1'b1;
      end
      ST_SHIFT: begin
        if (sts_i.shift_end) begin
          cmd_o.rm_done = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      ST_INNER: begin
        if (sts_i.outer_end) begin
          if (sts_i.kind_setop && !pass_b_q && kind_q == KIND_UNION) begin
            pass_b_d        = 1'b1;
            cmd_o.pass_b    = 1'b1;
            cmd_o.outer_clr = 1'b1;
            cmd_o.inner_clr = 1'b1;
          end else begin
            state_d = ST_DONE;
          end
        end else if (!sts_i.inner_hit && !sts_i.inner_end) begin
          cmd_o.inner_step = 1'b1;
        end else begin
          state_d = ST_OUTER;
        end
      end
      ST_OUTER: begin
        if (sts_i.kind_cmp) begin
          cmd_o.cnt_common = sts_i.inner_hit;
          cmd_o.outer_step = 1'b1;
          cmd_o.inner_clr  = 1'b1;
          state_d          = ST_INNER;
        end else if (emit) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.outer_step = 1'b1;
          cmd_o.inner_clr  = 1'b1;
          state_d          = ST_INNER;
        end
      end
      ST_EMIT: begin
        // previous element goes out once a further one is known
        if (!sts_i.any_out) begin
          cmd_o.pend_load  = 1'b1;
          cmd_o.outer_step = 1'b1;
          cmd_o.inner_clr  = 1'b1;
          state_d          = ST_INNER;
        end else if (!sts_i.out_busy) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_elem   = 1'b1;
          cmd_o.pend_load  = 1'b1;
          cmd_o.outer_step = 1'b1;
          cmd_o.inner_clr  = 1'b1;
          state_d          = ST_INNER;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_last = 1'b1;
          if (sts_i.kind_perset) begin
            cmd_o.res_final = 1'b1;
            if (kind_q == KIND_ADD && !sts_i.found) cmd_o.do_add = 1'b1;
            if (kind_q == KIND_CLEAR) cmd_o.do_clear = 1'b1;
            state_d = (kind_q == KIND_REMOVE && sts_i.found) ? ST_SHIFT : ST_IDLE;
          end else if (sts_i.kind_cmp) begin
            cmd_o.res_final = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.res_elem = sts_i.any_out;
            state_d        = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

### hdl/integer_set_engine_unit.sv
// Integer set engine top level: controller plus datapath, stream ports.
// Depends on ise_pkg, ise_ctrl and ise_datapath.
// A per-set command scans the target set, then loads its result item; remove
// then compacts the entries behind the match. Set ops compare each element
// of one set against the other; union adds a pass of B over A. Output stalls
// lengthen both. One item in work at a time. Reset: async active low, counts zero.
module integer_set_engine_unit #(
  parameter int Capacity = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[31:0]
  input  logic [4:0]  s_axis_tuser,  // kind[3:0], which_set[4]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // answer[0], refused_full[1], element[33:2],
                                     // set_size[39:34], set_empty[40]
  output logic        m_axis_tuser,  // element_valid
  output logic        m_axis_tlast
);
  import ise_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ise_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .kind_i    (s_axis_tuser[3:0]),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ise_datapath #(.Capacity(Capacity)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .kind_i     (s_axis_tuser[3:0]),
    .which_set_i(s_axis_tuser[4]),
    .value_i    (s_axis_tdata),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_data_o (m_axis_tdata),
    .res_user_o (m_axis_tuser),
    .res_last_o (m_axis_tlast)
  );
endmodule
